/* hdl/causal_attention_head_defines.svh */
// Assertion macros for the causal attention head RTL.
// No dependencies; included by the top level only.
`ifndef CAUSAL_ATTENTION_HEAD_DEFINES_SVH
`define CAUSAL_ATTENTION_HEAD_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CAH_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define CAH_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define CAH_ASSERT_SAME(lbl, a, b)
`define CAH_ASSERT_NEXT(lbl, a, b)
`endif
`endif

/* hdl/cah_pkg.sv */
// Shared types, constants and the exponent table for the attention head.
// No dependencies.
package cah_pkg;

    localparam int MAX_SEQ  = 128;
    localparam int MAX_HEAD = 64;
    localparam int POS_W    = $clog2(MAX_SEQ);
    localparam int IDX_W    = 6;
    localparam int KV_AW    = POS_W + IDX_W;
    localparam int SUM_W    = POS_W + 18;
    localparam int NUM_W    = (SUM_W > 33) ? SUM_W + 1 : 34;
    localparam int ACC_W    = 34 + $clog2(MAX_SEQ + MAX_HEAD);
    localparam int HI_W     = ACC_W - 19 + 17;

    localparam logic signed [31:0] SCORE_FLOOR = -32'sd10240000;
    localparam logic [10:0]        LOG2E_Q10   = 11'd1477;

    localparam logic REG_HSIZE = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    typedef struct packed {
        logic [6:0]         position;
        logic [5:0]         element_index;
        logic signed [15:0] query_element;
        logic signed [15:0] key_element;
        logic signed [15:0] value_element;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic [5:0]         out_index;
        logic               out_last;
    } result_t;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_DOT    = 16'h0002,
        S_DDRAIN = 16'h0004,
        S_SCL1   = 16'h0008,
        S_SCL2   = 16'h0010,
        S_SCL3   = 16'h0020,
        S_ERD    = 16'h0040,
        S_EX1    = 16'h0080,
        S_EX2    = 16'h0100,
        S_EX3    = 16'h0200,
        S_ESUM   = 16'h0400,
        S_DIV    = 16'h0800,
        S_WWR    = 16'h1000,
        S_OSTR   = 16'h2000,
        S_ODRAIN = 16'h4000,
        S_OFIN   = 16'h8000
    } state_t;

    // round(65536 * 2^(-i/16))
    function automatic logic [16:0] pow2_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37315;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

/* hdl/cah_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cah_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/causal_attention_head.sv */
// Causal attention head, top level: control sequencer, arithmetic and RAMs.
// Depends on cah_pkg, cah_ram and causal_attention_head_defines.svh.
//
// Each transfer on start/busy writes one query/key/value element if its index
// is below the head size. The last element of the head vector starts the
// computation for that position; busy stays high until all results of the head
// have been strobed out on result_valid, one at a time, each for a single cycle
// (the receiver cannot stall). A completing item computes the scores, then the
// exponent sum, then the weights (one restoring divider, one quotient bit per
// cycle) and then the weighted value sums; everything runs through one shared
// multiply-accumulate pipe fed by key/value and query RAMs with one read port each.
`include "causal_attention_head_defines.svh"
module causal_attention_head (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  cah_pkg::cmd_t  command,
    output logic           result_valid,
    output cah_pkg::result_t result,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int CNT_W = $clog2(cah_pkg::NUM_W + 1);
    localparam logic signed [cah_pkg::ACC_W-1:0] HALF_LSB = cah_pkg::ACC_W'(32768);
    localparam logic signed [cah_pkg::ACC_W-1:0] OUT_MAX  = cah_pkg::ACC_W'(32767);
    localparam logic signed [cah_pkg::ACC_W-1:0] OUT_MIN  = -cah_pkg::ACC_W'(32768);

    // configuration
    logic [6:0]  hs_reg;
    logic [15:0] scale_reg;
    logic [6:0]  hs_used;
    logic        cfg_wr;

    // sequencer
    cah_pkg::state_t state_reg, state_next;
    logic [cah_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [cah_pkg::POS_W-1:0] t_reg, t_next;
    logic [5:0] hsm1_reg, hsm1_next;
    logic [5:0] i_reg, i_next;
    logic ph_out_reg, ph_out_next;
    logic wph_reg, wph_next;

    // MAC pipe
    logic rd_v_reg, rd_v_next;
    logic mul_v_reg, mul_v_next;
    logic signed [33:0] prod_reg, prod_next;
    logic signed [cah_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [16:0] op_a, op_b;

    // scaling
    logic [34:0] plo_reg, plo_next;
    logic signed [cah_pkg::HI_W-1:0] phi_reg, phi_next;
    logic signed [cah_pkg::ACC_W+16:0] scaled;
    logic signed [31:0] score;
    logic signed [31:0] max_reg, max_next;

    // exponent
    logic signed [32:0] delta;
    logic [24:0] x_reg, x_next;
    logic big_reg, big_next;
    logic zero_reg, zero_next;
    logic [4:0] k_reg, k_next;
    logic [16:0] ti_reg, ti_next;
    logic [16:0] tn;
    logic [11:0] tdiff;
    logic [27:0] dp_reg, dp_next;
    logic [16:0] mant;
    logic [16:0] e_reg, e_next;
    logic [cah_pkg::SUM_W-1:0] sum_reg, sum_next;

    // divider
    logic [cah_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [cah_pkg::NUM_W-1:0] num_reg, num_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [cah_pkg::SUM_W:0] rem_sh;
    logic [15:0] weight;

    // output rounding
    logic signed [cah_pkg::ACC_W-1:0] rnd;
    logic signed [15:0] oval;

    logic res_valid_reg, res_valid_next;
    cah_pkg::result_t res_reg, res_next;

    // input side
    logic in_xfer, in_ok, in_trig;
    logic [cah_pkg::KV_AW-1:0] kv_waddr, kv_raddr;

    // RAM ports
    logic [15:0] q_rdata;
    logic [31:0] kv_rdata;
    logic [31:0] sc_rdata;
    logic [15:0] w_rdata;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == cah_pkg::REG_HSIZE) ? {25'd0, hs_reg}
                                                      : {16'd0, scale_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg    <= 7'd64;
            scale_reg <= 16'd8192;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == cah_pkg::REG_HSIZE)
            begin
                hs_reg <= pwdata[6:0];
            end
            else
            begin
                scale_reg <= pwdata[15:0];
            end
        end
    end

    // head sizes of zero or above the maximum are clamped
    always_comb
    begin
        if (hs_reg == 7'd0)
        begin
            hs_used = 7'd1;
        end
        else if (hs_reg > 7'(cah_pkg::MAX_HEAD))
        begin
            hs_used = 7'(cah_pkg::MAX_HEAD);
        end
        else
        begin
            hs_used = hs_reg;
        end
    end

    // ---------------- input transfer ----------------
    assign busy     = (state_reg != cah_pkg::S_IDLE) || res_valid_reg;
    assign in_xfer  = start && !busy;
    assign in_ok    = in_xfer && (32'(command.position) < cah_pkg::MAX_SEQ)
                      && ({1'b0, command.element_index} < hs_used);
    assign in_trig  = in_ok && ({1'b0, command.element_index} == hs_used - 7'd1);
    assign kv_waddr = {cah_pkg::POS_W'(command.position), command.element_index};
    assign kv_raddr = {t_reg, i_reg};

    // ---------------- memories ----------------
    cah_ram #(.WIDTH(16), .DEPTH(cah_pkg::MAX_HEAD)) u_q_ram (
        .clk   (clk),
        .we    (in_ok),
        .waddr (command.element_index),
        .wdata (command.query_element),
        .raddr (i_reg),
        .rdata (q_rdata)
    );

    // value in the upper half, key in the lower half
    cah_ram #(.WIDTH(32), .DEPTH(cah_pkg::MAX_SEQ * cah_pkg::MAX_HEAD)) u_kv_ram (
        .clk   (clk),
        .we    (in_ok),
        .waddr (kv_waddr),
        .wdata ({command.value_element, command.key_element}),
        .raddr (kv_raddr),
        .rdata (kv_rdata)
    );

    cah_ram #(.WIDTH(32), .DEPTH(cah_pkg::MAX_SEQ)) u_score_ram (
        .clk   (clk),
        .we    (state_reg == cah_pkg::S_SCL3),
        .waddr (t_reg),
        .wdata (score),
        .raddr (t_reg),
        .rdata (sc_rdata)
    );

    cah_ram #(.WIDTH(16), .DEPTH(cah_pkg::MAX_SEQ)) u_weight_ram (
        .clk   (clk),
        .we    (state_reg == cah_pkg::S_WWR),
        .waddr (t_reg),
        .wdata (weight),
        .raddr (t_reg),
        .rdata (w_rdata)
    );

    // ---------------- datapath helpers ----------------
    // MAC operands: q*k for scores, weight*v for outputs
    assign op_a = ph_out_reg ? $signed({1'b0, w_rdata}) : $signed({q_rdata[15], q_rdata});
    assign op_b = ph_out_reg ? $signed({kv_rdata[31], kv_rdata[31:16]})
                             : $signed({kv_rdata[15], kv_rdata[15:0]});

    // score = floor(dot * scale / 2^26), dot split in a signed high and unsigned low part
    always_comb
    begin
        scaled = phi_reg;
        scaled = (scaled <<< 19) + $signed({{(cah_pkg::ACC_W-18){1'b0}}, plo_reg});
        score  = 32'(scaled >>> 26);
    end

    assign delta = $signed(max_reg) - $signed(sc_rdata);
    assign tn    = cah_pkg::pow2_tab(5'({1'b0, x_reg[19:16]}) + 5'd1);
    assign tdiff = 12'(cah_pkg::pow2_tab({1'b0, x_reg[19:16]}) - tn);
    assign mant  = ti_reg - 17'(dp_reg[27:16]);
    assign rem_sh = {rem_reg, num_reg[cah_pkg::NUM_W-1]};
    assign weight = (num_reg > cah_pkg::NUM_W'(16'hFFFF)) ? 16'hFFFF : num_reg[15:0];

    always_comb
    begin
        rnd = (acc_reg + HALF_LSB) >>> 16;
        if (rnd > OUT_MAX)
        begin
            oval = 16'sh7FFF;
        end
        else if (rnd < OUT_MIN)
        begin
            oval = -16'sh8000;
        end
        else
        begin
            oval = 16'(rnd);
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        t_next         = t_reg;
        hsm1_next      = hsm1_reg;
        i_next         = i_reg;
        ph_out_next    = ph_out_reg;
        wph_next       = wph_reg;
        rd_v_next      = 1'b0;
        mul_v_next     = rd_v_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        max_next       = max_reg;
        x_next         = x_reg;
        big_next       = big_reg;
        zero_next      = zero_reg;
        k_next         = k_reg;
        ti_next        = ti_reg;
        dp_next        = dp_reg;
        e_next         = e_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        dcnt_next      = dcnt_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        if (rd_v_reg)
        begin
            prod_next = op_a * op_b;
        end
        if (mul_v_reg)
        begin
            acc_next = acc_reg + prod_reg;
        end

        case (state_reg)
            cah_pkg::S_IDLE:
            begin
                if (in_trig)
                begin
                    pos_next    = cah_pkg::POS_W'(command.position);
                    hsm1_next   = 6'(hs_used - 7'd1);
                    t_next      = '0;
                    i_next      = '0;
                    acc_next    = '0;
                    max_next    = cah_pkg::SCORE_FLOOR;
                    ph_out_next = 1'b0;
                    state_next  = cah_pkg::S_DOT;
                end
            end
            cah_pkg::S_DOT:
            begin
                rd_v_next = 1'b1;
                if (i_reg == hsm1_reg)
                begin
                    state_next = cah_pkg::S_DDRAIN;
                end
                else
                begin
                    i_next = i_reg + 6'd1;
                end
            end
            cah_pkg::S_DDRAIN:
            begin
                if (!rd_v_reg && !mul_v_reg)
                begin
                    state_next = cah_pkg::S_SCL1;
                end
            end
            cah_pkg::S_SCL1:
            begin
                plo_next   = acc_reg[18:0] * scale_reg;
                state_next = cah_pkg::S_SCL2;
            end
            cah_pkg::S_SCL2:
            begin
                phi_next   = $signed(acc_reg[cah_pkg::ACC_W-1:19]) * $signed({1'b0, scale_reg});
                state_next = cah_pkg::S_SCL3;
            end
            cah_pkg::S_SCL3:
            begin
                if (score > max_reg)
                begin
                    max_next = score;
                end
                if (t_reg == pos_reg)
                begin
                    t_next     = '0;
                    sum_next   = '0;
                    wph_next   = 1'b0;
                    state_next = cah_pkg::S_ERD;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = cah_pkg::S_DOT;
                end
            end
            cah_pkg::S_ERD:
            begin
                state_next = cah_pkg::S_EX1;
            end
            cah_pkg::S_EX1:
            begin
                // distances of 2^14 and up underflow the exponent anyway
                big_next   = (delta[32:14] != '0);
                x_next     = delta[13:0] * cah_pkg::LOG2E_Q10;
                state_next = cah_pkg::S_EX2;
            end
            cah_pkg::S_EX2:
            begin
                k_next     = x_reg[24:20];
                zero_next  = big_reg || (x_reg[24:20] >= 5'd17);
                ti_next    = cah_pkg::pow2_tab({1'b0, x_reg[19:16]});
                dp_next    = tdiff * x_reg[15:0];
                state_next = cah_pkg::S_EX3;
            end
            cah_pkg::S_EX3:
            begin
                e_next = zero_reg ? 17'd0 : (mant >> k_reg);
                if (!wph_reg)
                begin
                    state_next = cah_pkg::S_ESUM;
                end
                else if (sum_reg == '0)
                begin
                    num_next   = '0;
                    state_next = cah_pkg::S_WWR;
                end
                else
                begin
                    num_next   = cah_pkg::NUM_W'({e_next, 16'd0})
                               + cah_pkg::NUM_W'(sum_reg >> 1);
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = cah_pkg::S_DIV;
                end
            end
            cah_pkg::S_ESUM:
            begin
                sum_next = sum_reg + cah_pkg::SUM_W'(e_reg);
                if (t_reg == pos_reg)
                begin
                    t_next   = '0;
                    wph_next = 1'b1;
                end
                else
                begin
                    t_next = t_reg + 1'b1;
                end
                state_next = cah_pkg::S_ERD;
            end
            cah_pkg::S_DIV:
            begin
                // restoring division, quotient shifts into num_reg
                if (rem_sh >= {1'b0, sum_reg})
                begin
                    rem_next = cah_pkg::SUM_W'(rem_sh - {1'b0, sum_reg});
                    num_next = {num_reg[cah_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[cah_pkg::SUM_W-1:0];
                    num_next = {num_reg[cah_pkg::NUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == CNT_W'(cah_pkg::NUM_W - 1))
                begin
                    state_next = cah_pkg::S_WWR;
                end
            end
            cah_pkg::S_WWR:
            begin
                if (t_reg == pos_reg)
                begin
                    t_next      = '0;
                    i_next      = '0;
                    acc_next    = '0;
                    ph_out_next = 1'b1;
                    state_next  = cah_pkg::S_OSTR;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = cah_pkg::S_ERD;
                end
            end
            cah_pkg::S_OSTR:
            begin
                rd_v_next = 1'b1;
                if (t_reg == pos_reg)
                begin
                    state_next = cah_pkg::S_ODRAIN;
                end
                else
                begin
                    t_next = t_reg + 1'b1;
                end
            end
            cah_pkg::S_ODRAIN:
            begin
                if (!rd_v_reg && !mul_v_reg)
                begin
                    state_next = cah_pkg::S_OFIN;
                end
            end
            cah_pkg::S_OFIN:
            begin
                res_valid_next     = 1'b1;
                res_next.out_value = oval;
                res_next.out_index = i_reg;
                res_next.out_last  = (i_reg == hsm1_reg);
                if (i_reg == hsm1_reg)
                begin
                    state_next = cah_pkg::S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 6'd1;
                    t_next     = '0;
                    acc_next   = '0;
                    state_next = cah_pkg::S_OSTR;
                end
            end
            default:
            begin
                state_next = cah_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cah_pkg::S_IDLE;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            ph_out_reg    <= 1'b0;
            wph_reg       <= 1'b0;
            t_reg         <= '0;
            i_reg         <= '0;
            pos_reg       <= '0;
            hsm1_reg      <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_v_reg      <= rd_v_next;
            mul_v_reg     <= mul_v_next;
            res_valid_reg <= res_valid_next;
            ph_out_reg    <= ph_out_next;
            wph_reg       <= wph_next;
            t_reg         <= t_next;
            i_reg         <= i_next;
            pos_reg       <= pos_next;
            hsm1_reg      <= hsm1_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        max_reg  <= max_next;
        x_reg    <= x_next;
        big_reg  <= big_next;
        zero_reg <= zero_next;
        k_reg    <= k_next;
        ti_reg   <= ti_next;
        dp_reg   <= dp_next;
        e_reg    <= e_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        res_reg  <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // ---------------- assertions ----------------
    // the last element of a position is a single strobe, never followed at once
    `CAH_ASSERT_NEXT(a_last_single, result_valid && result.out_last, !result_valid)
    // the finishing step always produces a strobed transfer
    `CAH_ASSERT_NEXT(a_fin_strobe, state_reg == cah_pkg::S_OFIN, result_valid)
    // a completing item blocks further input on the next cycle
    `CAH_ASSERT_NEXT(a_trig_busy, in_trig, busy)
    // the MAC pipe is empty whenever the block is idle
    `CAH_ASSERT_SAME(a_idle_drained, state_reg == cah_pkg::S_IDLE, !rd_v_reg && !mul_v_reg)

endmodule

/* tb/causal_attention_head_tb.sv */
// Self-checking testbench for the causal attention head: stimulus, scoreboard.
// Depends on cah_pkg and the causal_attention_head RTL.
module causal_attention_head_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEQ  = cah_pkg::MAX_SEQ;
    localparam int MAX_HEAD = cah_pkg::MAX_HEAD;

    localparam int SETTLE_CYCLES = 8;
    localparam logic [2:0] ADDR_HSIZE = 3'd0;
    localparam logic [2:0] ADDR_SCALE = 3'd4;

    // 65536 * 2^(-i/16), rounded
    localparam longint EXP2_FRAC [0:16] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
        46341, 44376, 42495, 40693, 38968, 37315, 35734, 34219, 32768
    };

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cah_pkg::cmd_t    command;
    logic             result_valid;
    cah_pkg::result_t result;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    causal_attention_head uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ---------------------------------------------------------------
    // Predictor state: register copies plus the key/value/query stores
    // ---------------------------------------------------------------
    logic [6:0]         cfg_hsize;
    logic [15:0]        cfg_scale;
    logic signed [15:0] key_mem   [0:MAX_SEQ*MAX_HEAD-1];
    logic signed [15:0] value_mem [0:MAX_SEQ*MAX_HEAD-1];
    logic signed [15:0] query_mem [0:MAX_HEAD-1];

    // Which store entries the stimulus has written so far; a position only
    // completes when everything it reads has been written.
    bit                 kv_written    [0:MAX_SEQ*MAX_HEAD-1];
    bit                 query_written [0:MAX_HEAD-1];

    cah_pkg::result_t   expected_outputs [$];
    cah_pkg::cmd_t      pending_cmds [$];
    int                 mismatch_count;
    int                 gap_max;

    function automatic int used_heads(input logic [6:0] hs);
        if (hs == 7'd0)
            return 1;
        if (hs > MAX_HEAD)
            return MAX_HEAD;
        return int'(hs);
    endfunction

    // exp(-d) for a Q.10 distance from the max, as Q0.16
    function automatic longint exp_neg_q16(input longint delta);
        longint x;
        longint shift;
        longint frac;
        longint seg;
        longint r;
        longint m;
        x = delta * 1477;
        shift = x >> 20;
        if (shift >= 17)
            return 0;
        frac = x & 64'hFFFFF;
        seg = frac >> 16;
        r = frac & 64'hFFFF;
        m = EXP2_FRAC[seg] - (((EXP2_FRAC[seg] - EXP2_FRAC[seg+1]) * r) >> 16);
        return m >> shift;
    endfunction

    // Apply one accepted element; when it closes a position, queue the
    // attention outputs for that position.
    function automatic void attend_element(input cah_pkg::cmd_t c);
        int hs;
        int pos;
        int idx;
        longint scores [0:MAX_SEQ-1];
        longint weights [0:MAX_SEQ-1];
        longint max_score;
        longint exp_sum;
        longint dot;
        longint acc;
        longint e;
        cah_pkg::result_t r;
        hs = used_heads(cfg_hsize);
        pos = int'(c.position);
        idx = int'(c.element_index);
        if (idx >= hs)
            return;
        query_mem[idx] = c.query_element;
        key_mem[pos*MAX_HEAD + idx] = c.key_element;
        value_mem[pos*MAX_HEAD + idx] = c.value_element;
        if (idx != hs - 1)
            return;
        max_score = -64'sd10240000;
        for (int t = 0; t <= pos; t++)
        begin
            dot = 0;
            for (int i = 0; i < hs; i++)
                dot += longint'(query_mem[i]) * longint'(key_mem[t*MAX_HEAD + i]);
            scores[t] = (dot * longint'(cfg_scale)) >>> 26;
            if (scores[t] > max_score)
                max_score = scores[t];
        end
        exp_sum = 0;
        for (int t = 0; t <= pos; t++)
            exp_sum += exp_neg_q16(max_score - scores[t]);
        for (int t = 0; t <= pos; t++)
        begin
            weights[t] = 0;
            if (exp_sum != 0)
            begin
                e = exp_neg_q16(max_score - scores[t]);
                weights[t] = (e * 65536 + exp_sum / 2) / exp_sum;
                if (weights[t] > 65535)
                    weights[t] = 65535;
            end
        end
        for (int i = 0; i < hs; i++)
        begin
            acc = 0;
            for (int t = 0; t <= pos; t++)
                acc += weights[t] * longint'(value_mem[t*MAX_HEAD + i]);
            acc = (acc + 32768) >>> 16;
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            r.out_value = acc[15:0];
            r.out_index = i[5:0];
            r.out_last = (i == hs - 1);
            expected_outputs.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: one command per transfer, random gap drawn per item
    // ---------------------------------------------------------------
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                attend_element(command);
            // slot is free when nothing is offered or the offer just went through
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    command <= pending_cmds.pop_front();
                    start <= 1'b1;
                    gap_left <= $urandom_range(0, gap_max);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: results cannot be stalled, check each one as it strobes
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %0d index %0d last %0b",
                             result.out_value, result.out_index, result.out_last);
            end
            else
            begin
                cah_pkg::result_t want;
                want = expected_outputs.pop_front();
                if (result.out_value !== want.out_value
                    || result.out_index !== want.out_index
                    || result.out_last !== want.out_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.out_value, want.out_index, want.out_last,
                                 result.out_value, result.out_index, result.out_last);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------

    // True when a closing element at pos would read only written entries.
    function automatic bit reads_are_written(input int pos, input int hs);
        for (int i = 0; i < hs; i++)
        begin
            if (!query_written[i])
                return 0;
            for (int t = 0; t <= pos; t++)
                if (!kv_written[t*MAX_HEAD + i])
                    return 0;
        end
        return 1;
    endfunction

    task automatic queue_element(input int pos, input int idx,
                                 input logic [15:0] q, input logic [15:0] k,
                                 input logic [15:0] v);
        int hs;
        cah_pkg::cmd_t c;
        hs = used_heads(cfg_hsize);
        if (idx < hs)
        begin
            bit q_old;
            bit kv_old;
            q_old = query_written[idx];
            kv_old = kv_written[pos*MAX_HEAD + idx];
            query_written[idx] = 1;
            kv_written[pos*MAX_HEAD + idx] = 1;
            if (idx == hs - 1 && !reads_are_written(pos, hs))
            begin
                // would read never-written entries: undo, send ignored noise
                query_written[idx] = q_old;
                kv_written[pos*MAX_HEAD + idx] = kv_old;
                if (hs == MAX_HEAD)
                    return;
                idx = $urandom_range(hs, 63);
            end
        end
        c.position = pos[6:0];
        c.element_index = idx[5:0];
        c.query_element = q;
        c.key_element = k;
        c.value_element = v;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($signed($urandom_range(0, 4095)) - 2048);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Positions 0..last_pos in order; broken sequences drop or add elements.
    task automatic queue_sequence(input int last_pos, input bit broken, output int n);
        int hs;
        hs = used_heads(cfg_hsize);
        n = 0;
        for (int p = 0; p <= last_pos; p++)
            for (int i = 0; i < hs; i++)
            begin
                if (broken && $urandom_range(0, 7) == 0)
                    continue;
                if (broken && $urandom_range(0, 9) == 0)
                begin
                    queue_element($urandom_range(0, 127), $urandom_range(0, 63),
                                  rand_word(), rand_word(), rand_word());
                    n++;
                end
                queue_element(p, i, rand_word(), rand_word(), rand_word());
                n++;
            end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_HSIZE)
            cfg_hsize = data[6:0];
        else if (addr == ADDR_SCALE)
            cfg_scale = data[15:0];
    endtask

    // Sender holds off until every queued item is in and every result is out.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || busy || expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int n;
        int hs;
        int last_pos;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        gap_max = 6;
        cfg_hsize = 7'd64;
        cfg_scale = 16'd8192;
        foreach (kv_written[j])
            kv_written[j] = 0;
        foreach (query_written[j])
            query_written[j] = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale scale, anti-aligned q and k push every score
        // far below the floor, so the exponent sum is zero and outputs are 0.
        apb_write(ADDR_HSIZE, 32'd16);
        apb_write(ADDR_SCALE, 32'd65535);
        for (int i = 0; i < 16; i++)
            queue_element(0, i, 16'h8000, 16'h7FFF, (i % 2) ? 16'h8000 : 16'h7FFF);
        queue_element(0, 63, 16'h7FFF, 16'h8000, 16'hFFFF);   // beyond head size
        drain();

        // Directed: head size 0 acts as 1, zero scale gives uniform weights.
        apb_write(ADDR_HSIZE, 32'd0);
        apb_write(ADDR_SCALE, 32'd0);
        queue_element(0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_element(1, 0, 16'h8000, 16'h8000, 16'h8000);
        queue_element(2, 0, 16'hFFFF, 16'h0000, 16'h7FFF);
        queue_element(3, 0, 16'h0001, 16'hFFFF, 16'h7FFF);
        queue_element(5, 0, 16'h1234, 16'h4321, 16'h0F0F);    // skipped position
        drain();

        // Random phases; one runs at head size 127 (acts as the maximum).
        sent = 0;
        for (int phase = 0; sent < 200; phase++)
        begin
            if (phase == 2)
                apb_write(ADDR_HSIZE, 32'd127);
            else
                apb_write(ADDR_HSIZE, $urandom_range(1, 8));
            case ($urandom_range(0, 3))
                0: apb_write(ADDR_SCALE, 32'd0);
                1: apb_write(ADDR_SCALE, 32'd65535);
                default: apb_write(ADDR_SCALE, $urandom_range(0, 65535));
            endcase
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            hs = used_heads(cfg_hsize);
            last_pos = (hs == MAX_HEAD) ? 0 : $urandom_range(0, 24 / hs + 2);
            queue_sequence(last_pos, 1'b0, n);
            sent += n;
            if (hs != MAX_HEAD && $urandom_range(0, 2) == 0)
            begin
                queue_sequence($urandom_range(0, 4), 1'b1, n);
                sent += n;
            end
            drain();
        end

        if (mismatch_count == 0 && expected_outputs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1s;
        $display("TEST FAILED");
        $finish;
    end

endmodule
